// ===== design/bc_pkg.sv =====
package bc_pkg;

    localparam int MAX_N     = 32;
    localparam int NUM_CELLS = MAX_N + 1;
    localparam int N_W       = 6;
    localparam int COEF_W    = 30;

    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

// ===== design/bc_in_if.sv =====
interface bc_in_if;
    import bc_pkg::*;

    logic           valid;
    logic           ready;
    logic [N_W-1:0] total_n;
    logic [N_W-1:0] choose_k;

    modport source (output valid, output total_n, output choose_k, input ready);
    modport sink   (input valid, input total_n, input choose_k, output ready);
endinterface

// ===== design/bc_out_if.sv =====
interface bc_out_if;
    import bc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coefficient;
    logic              invalid;

    modport source (output valid, output coefficient, output invalid, input ready);
    modport sink   (input valid, input coefficient, input invalid, output ready);
endinterface

// ===== design/bc_cell.sv =====
module bc_cell (
    input  logic                       i_clk,
    input  bc_pkg::t_cell_ctrl         i_ctrl,
    input  logic [bc_pkg::N_W-1:0]     i_index,
    input  logic [bc_pkg::N_W-1:0]     i_sel_k,
    input  logic [bc_pkg::COEF_W-1:0]  i_left,
    output logic [bc_pkg::COEF_W-1:0]  o_val,
    output logic [bc_pkg::COEF_W-1:0]  o_pick
);
    import bc_pkg::*;

    logic [COEF_W-1:0] r_val;
    logic [COEF_W-1:0] n_val;
    logic [COEF_W:0]   sum;

    assign sum = {1'b0, r_val} + {1'b0, i_left};

    always_comb begin
        n_val = r_val;
        if (i_ctrl.load) begin
            n_val = (i_index == '0) ? COEF_W'(1) : '0;
        end else if (i_ctrl.step && (i_index != '0)) begin
            // pascal rule, saturating at the field limit
            n_val = sum[COEF_W] ? COEF_MAX : sum[COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_pick = (i_index == i_sel_k) ? r_val : '0;
endmodule

// ===== design/binomial_coefficient_unit.sv =====
// binomial coefficient unit: returns C(n,k) for a pair (total_n, choose_k)
// input channel i_in carries total_n and choose_k; output channel o_out
// carries coefficient and invalid, one result beat per input beat
// a row of MAX_N+1 cells holds one pascal row; all cells update together
// once per cycle, so row n is ready after n updates; the result then goes
// to the output register, and a new item is taken only once the previous
// one has left the cell row
// i_in.ready is high while no item is in the cell row; the next item is
// taken while an earlier result still waits in the output register
// k above n, or n above MAX_N: coefficient 0 and invalid 1, with no row update
// values wider than the coefficient field saturate to all ones
// reset (i_rst_n low, synchronous) empties the row and the output register
// when the receiver stalls, the result holds; a finished row waits in the
// cells until the output register is free, and no new item is taken
module binomial_coefficient_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bc_in_if.sink        i_in,
    bc_out_if.source     o_out
);
    import bc_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [N_W-1:0]    r_cnt;
    logic [N_W-1:0]    n_cnt;
    logic [N_W-1:0]    r_k;
    logic              r_inv;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [COEF_W-1:0] r_out_coef;
    logic              r_out_inv;

    t_cell_ctrl        cell_ctrl;
    logic [COEF_W-1:0] cell_val  [NUM_CELLS];
    logic [COEF_W-1:0] cell_pick [NUM_CELLS];
    logic [COEF_W-1:0] picked;

    logic in_fire;
    logic out_free;
    logic finish;
    logic bad_in;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign finish   = (r_state == ST_RUN) && (r_cnt == '0) && out_free;
    assign bad_in   = (i_in.choose_k > i_in.total_n) || (i_in.total_n > N_W'(MAX_N));

    assign i_in.ready = (r_state == ST_IDLE);

    assign cell_ctrl.load = in_fire;
    assign cell_ctrl.step = (r_state == ST_RUN) && (r_cnt != '0);

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        bc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_index (N_W'(g)),
            .i_sel_k (r_k),
            .i_left  ((g == 0) ? '0 : cell_val[(g == 0) ? 0 : g - 1]),
            .o_val   (cell_val[g]),
            .o_pick  (cell_pick[g])
        );
    end

    // only the cell whose index matches k drives a nonzero pick
    always_comb begin
        picked = '0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            picked = picked | cell_pick[i];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_RUN;
                    n_cnt   = bad_in ? '0 : i_in.total_n;
                end
            end
            ST_RUN: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - N_W'(1);
                end else if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_k   <= i_in.choose_k;
            r_inv <= bad_in;
        end
        if (finish) begin
            r_out_coef <= r_inv ? '0 : picked;
            r_out_inv  <= r_inv;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.coefficient = r_out_coef;
    assign o_out.invalid     = r_out_inv;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_RUN))
        else $error("accepted beat did not start the row");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.invalid) |-> (o_out.coefficient == '0))
        else $error("invalid result with nonzero coefficient");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.coefficient)))
        else $error("stalled result changed");
`endif
endmodule
